[design/iee_pkg.sv]
`default_nettype none
package iee_pkg;
	localparam int STACK_DEPTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int QDEPTH = 4;
	localparam int QP_W = $clog2(QDEPTH);
	localparam int DIV_STEPS = 48 + FRAC_BITS;
	localparam int DC_W = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_DIV0 = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef enum logic [2:0] {
		K_DIGIT, K_SPACE, K_OP, K_INVALID, K_END
	} kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] value;
		logic [2:0]         status;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic [1:0] op;
		logic       last;
	} token_t;
endpackage
`default_nettype wire

[design/infix_expression_evaluator.sv]
// A result leaves once the expression's last item and its reductions are done.
// The back end sequencer takes a new item only when it has finished the last one and
// its reductions, and not while a result is held by out_stall.
// A 4-entry queue lets the front accept items while the back end works.
// arst_n clears queue and back end counters and flags; stack contents are not reset.
`default_nettype none
module infix_expression_evaluator import iee_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);
	logic tok_valid, tok_pop;
	token_t tok;

	iee_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .tok_valid(tok_valid), .tok_pop(tok_pop), .tok(tok)
	);

	iee_back u_back (
		.clk(clk), .arst_n(arst_n), .tok_valid(tok_valid), .tok_pop(tok_pop),
		.tok(tok), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule
`default_nettype wire

[design/iee_front.sv]
`default_nettype none
module iee_front import iee_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_item_t in_data,
	output logic          tok_valid,
	input  wire logic     tok_pop,
	output token_t        tok
);
	token_t q_mem [QDEPTH];
	logic [QP_W:0] wr_q, rd_q;
	token_t t;
	logic push;

	always_comb begin
		t = '0;
		t.last = in_data.last;
		t.digit = in_data.char_code[3:0];
		case (in_data.char_code) inside
			["0":"9"]: t.kind = K_DIGIT;
			" ": t.kind = K_SPACE;
			"+": begin t.kind = K_OP; t.op = OP_ADD; end
			"-": begin t.kind = K_OP; t.op = OP_SUB; end
			"*": begin t.kind = K_OP; t.op = OP_MUL; end
			"/": begin t.kind = K_OP; t.op = OP_DIV; end
			8'h0a, 8'h00: t.kind = K_END;
			default: t.kind = K_INVALID;
		endcase
	end

	assign in_stall = (wr_q - rd_q) == (QP_W + 1)'(QDEPTH);
	assign push = in_valid && !in_stall;
	assign tok_valid = wr_q != rd_q;
	assign tok = q_mem[rd_q[QP_W-1:0]];

	always_ff @(posedge clk) if (push) q_mem[wr_q[QP_W-1:0]] <= t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (tok_pop && tok_valid) rd_q <= rd_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

[design/iee_alu.sv]
`default_nettype none
module iee_alu import iee_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         op,
	input  wire logic signed [47:0] a,
	input  wire logic signed [47:0] b,
	output logic                    done,
	output logic signed [47:0]      res,
	output logic                    sat
);
	typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_DIV, S_FIN} st_t;
	st_t st_q;
	logic [1:0] op_q;
	logic neg_q;
	logic [47:0] ua_q, ub_q;
	logic [95:0] prod_q;
	logic [47:0] ppa_q, ppb_q, ppc_q, ppd_q;
	logic [48:0] r_q;
	logic [49:0] q_q;
	logic big_q;
	logic [DC_W-1:0] cnt_q;
	logic signed [48:0] sum;
	logic [48:0] r_sh, r_sub;
	logic bit_in;
	logic [95:0] shifted;
	logic [49:0] mq;
	logic mbig;
	logic [49:0] lim;
	logic [49:0] fq;
	logic fbig;
	logic fsat;
	logic [47:0] fmag;

	assign sum = (op_q == OP_SUB) ? 49'(a) - 49'(b) : 49'(a) + 49'(b);
	assign bit_in = (cnt_q < DC_W'(48)) ? ua_q[47 - cnt_q[5:0]] : 1'b0;
	assign r_sh = {r_q[47:0], bit_in};
	assign r_sub = r_sh - 49'(ub_q);
	assign shifted = prod_q >> FRAC_BITS;
	assign mq = shifted[49:0];
	assign mbig = |shifted[95:50];
	assign lim = neg_q ? 50'h0_8000_0000_0000 : 50'h0_7FFF_FFFF_FFFF;
	assign fbig = (op_q == OP_MUL) ? mbig : big_q;
	assign fq = (op_q == OP_MUL) ? mq : q_q;
	assign fsat = fbig || (fq > lim);
	assign fmag = fsat ? lim[47:0] : fq[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					done <= 1'b0;
					if (start) begin
						op_q <= op;
						neg_q <= a[47] ^ b[47];
						ua_q <= a[47] ? 48'(-a) : a;
						ub_q <= b[47] ? 48'(-b) : b;
						r_q <= '0;
						q_q <= '0;
						big_q <= 1'b0;
						cnt_q <= '0;
						if (op == OP_ADD || op == OP_SUB) st_q <= S_FIN;
						else if (op == OP_MUL) st_q <= S_MUL1;
						else st_q <= S_DIV;
					end
				end
				S_FIN: begin
					if (op_q == OP_ADD || op_q == OP_SUB) begin
						sat <= sum[48] != sum[47];
						res <= (sum[48] != sum[47]) ?
							(sum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF) : sum[47:0];
					end else begin
						sat <= fsat;
						res <= neg_q ? 48'(-fmag) : fmag;
					end
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				S_MUL1: begin
					ppa_q <= 48'(ua_q[23:0] * ub_q[23:0]);
					ppb_q <= 48'(ua_q[47:24] * ub_q[23:0]);
					ppc_q <= 48'(ua_q[23:0] * ub_q[47:24]);
					ppd_q <= 48'(ua_q[47:24] * ub_q[47:24]);
					st_q <= S_MUL2;
				end
				S_MUL2: begin
					prod_q <= 96'(ppa_q) + (96'(ppb_q) << 24) + (96'(ppc_q) << 24)
						+ (96'(ppd_q) << 48);
					st_q <= S_FIN;
				end
				S_DIV: begin
					if (r_sh >= 49'(ub_q)) r_q <= r_sub;
					else r_q <= r_sh;
					if (q_q > 50'h1_0000_0000_0000) big_q <= 1'b1;
					else q_q <= {q_q[48:0], r_sh >= 49'(ub_q)};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DC_W'(DIV_STEPS - 1)) st_q <= S_FIN;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/iee_back.sv]
`default_nettype none
module iee_back import iee_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic tok_valid,
	output logic      tok_pop,
	input  wire token_t tok,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_item_t out_data
);
	typedef enum logic [2:0] {
		B_IDLE, B_TOKEN, B_RED_RD, B_RED_WAIT, B_FIN, B_FIN2
	} bst_t;

	logic signed [47:0] nstk [STACK_DEPTH];
	logic [1:0] ostk [STACK_DEPTH];
	bst_t st_q;
	token_t tk_q;
	logic [CNT_W-1:0] ncnt_q, ocnt_q;
	logic [30:0] acc_q;
	logic innum_q, skip_q, satf_q;
	logic end_q;
	logic signed [47:0] a_q, b_q;
	logic [1:0] rop_q;
	logic alu_start;
	logic alu_done, alu_sat;
	logic signed [47:0] alu_res;
	logic [34:0] acc10;
	logic [1:0] top_op;

	iee_alu u_alu (
		.clk(clk), .arst_n(arst_n), .start(alu_start), .op(rop_q),
		.a(a_q), .b(b_q), .done(alu_done), .res(alu_res), .sat(alu_sat)
	);

	assign acc10 = 35'(acc_q) * 35'd10 + 35'(tk_q.digit);
	assign top_op = ostk[SP_W'(ocnt_q - 1'b1)];
	assign tok_pop = (st_q == B_IDLE) && tok_valid && !(out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			ncnt_q <= '0;
			ocnt_q <= '0;
			acc_q <= '0;
			innum_q <= 1'b0;
			skip_q <= 1'b0;
			satf_q <= 1'b0;
			out_valid <= 1'b0;
			alu_start <= 1'b0;
			end_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				B_IDLE: if (tok_pop) begin
					tk_q <= tok;
					st_q <= B_TOKEN;
				end
				B_TOKEN: begin
					end_q <= 1'b0;
					if (skip_q) st_q <= B_FIN2;
					else if (tk_q.kind == K_DIGIT) begin
						if (acc10 > 35'h7FFF_FFFF) begin
							acc_q <= 31'h7FFF_FFFF;
							satf_q <= 1'b1;
						end else acc_q <= acc10[30:0];
						innum_q <= 1'b1;
						st_q <= tk_q.last ? B_FIN : B_FIN2;
					end else if (innum_q) begin
						innum_q <= 1'b0;
						if (ncnt_q == CNT_W'(STACK_DEPTH)) begin
							out_data <= '{48'sd0, ST_OVERFLOW, satf_q};
							out_valid <= 1'b1;
							skip_q <= 1'b1;
							st_q <= B_FIN2;
						end else begin
							nstk[SP_W'(ncnt_q)] <= 48'({acc_q, {FRAC_BITS{1'b0}}});
							ncnt_q <= ncnt_q + 1'b1;
							acc_q <= '0;
						end
					end else begin
						case (tk_q.kind)
							K_SPACE: begin
								st_q <= tk_q.last ? B_FIN : B_FIN2;
							end
							K_END: st_q <= B_FIN;
							K_INVALID: begin
								out_data <= '{48'sd0, ST_INVALID, satf_q};
								out_valid <= 1'b1;
								skip_q <= 1'b1;
								st_q <= B_FIN2;
							end
							K_OP: begin
								if (ocnt_q != '0 && top_op[1] >= tk_q.op[1]) st_q <= B_RED_RD;
								else if (ocnt_q == CNT_W'(STACK_DEPTH)) begin
									out_data <= '{48'sd0, ST_OVERFLOW, satf_q};
									out_valid <= 1'b1;
									skip_q <= 1'b1;
									st_q <= B_FIN2;
								end else begin
									ostk[SP_W'(ocnt_q)] <= tk_q.op;
									ocnt_q <= ocnt_q + 1'b1;
									st_q <= tk_q.last ? B_FIN : B_FIN2;
								end
							end
							default: st_q <= B_FIN2;
						endcase
					end
				end
				B_RED_RD: begin
					if (ncnt_q < CNT_W'(2)) begin
						out_data <= '{48'sd0, ST_MISSING, satf_q};
						out_valid <= 1'b1;
						skip_q <= 1'b1;
						st_q <= B_FIN2;
					end else if (top_op == OP_DIV && nstk[SP_W'(ncnt_q - 1'b1)] == '0) begin
						out_data <= '{48'sd0, ST_DIV0, satf_q};
						out_valid <= 1'b1;
						skip_q <= 1'b1;
						st_q <= B_FIN2;
					end else begin
						b_q <= nstk[SP_W'(ncnt_q - 1'b1)];
						a_q <= nstk[SP_W'(ncnt_q - CNT_W'(2))];
						rop_q <= top_op;
						alu_start <= 1'b1;
						st_q <= B_RED_WAIT;
					end
				end
				B_RED_WAIT: begin
					alu_start <= 1'b0;
					if (alu_done) begin
						nstk[SP_W'(ncnt_q - CNT_W'(2))] <= alu_res;
						ncnt_q <= ncnt_q - 1'b1;
						ocnt_q <= ocnt_q - 1'b1;
						if (alu_sat) satf_q <= 1'b1;
						st_q <= end_q ? B_FIN : B_TOKEN;
					end
				end
				B_FIN: begin
					end_q <= 1'b1;
					if (innum_q) begin
						innum_q <= 1'b0;
						if (ncnt_q == CNT_W'(STACK_DEPTH)) begin
							out_data <= '{48'sd0, ST_OVERFLOW, satf_q};
							out_valid <= 1'b1;
							skip_q <= 1'b1;
							st_q <= B_FIN2;
						end else begin
							nstk[SP_W'(ncnt_q)] <= 48'({acc_q, {FRAC_BITS{1'b0}}});
							ncnt_q <= ncnt_q + 1'b1;
							acc_q <= '0;
						end
					end else if (ocnt_q != '0) st_q <= B_RED_RD;
					else begin
						if (ncnt_q == '0) out_data <= '{48'sd0, ST_MISSING, satf_q};
						else out_data <= '{nstk[0], ST_OK, satf_q};
						out_valid <= 1'b1;
						skip_q <= 1'b1;
						st_q <= B_FIN2;
					end
				end
				B_FIN2: begin
					if (tk_q.last) begin
						ncnt_q <= '0;
						ocnt_q <= '0;
						acc_q <= '0;
						innum_q <= 1'b0;
						skip_q <= 1'b0;
						satf_q <= 1'b0;
					end
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
